### rtl/core/spt_pkg.sv
// shared constants, codes and types of the shortest-path trajectory compressor
// used by every module under rtl/core; depends on nothing
package spt_pkg;

    localparam int NODE_COUNT = 1024;
    localparam int EDGE_COUNT = 4096;
    localparam int NODE_W     = $clog2(NODE_COUNT);
    localparam int EDGE_W     = $clog2(EDGE_COUNT);
    localparam int PATH_DEPTH = NODE_COUNT * NODE_COUNT;
    localparam int PATH_AW    = 2 * NODE_W;
    localparam int REQ_W      = 2;
    localparam int KIND_W     = 2;
    localparam int VALUE_W    = 12;
    localparam int OBUF_DEPTH = 4;
    localparam int OBUF_AW    = $clog2(OBUF_DEPTH);
    localparam int OBUF_CW    = OBUF_AW + 1;

    localparam logic [REQ_W-1:0] REQ_EDGE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_PATH = 2'd1;
    localparam logic [REQ_W-1:0] REQ_TRAJ = 2'd2;

    localparam logic [KIND_W-1:0] KIND_ANCHOR = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RAW    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FINAL  = 2'd2;

    typedef struct packed {
        logic [NODE_W-1:0] start_node;
        logic [NODE_W-1:0] end_node;
    } endpoints_t;

    typedef struct packed {
        logic              valid;
        logic [EDGE_W-1:0] id;
    } path_entry_t;

    typedef struct packed {
        logic [NODE_W-1:0] anchor;
        logic [NODE_W-1:0] run_end;
        logic              in_run;
        logic              prev_raw;
        logic              started;
    } traj_state_t;

    // item in the decide stage, with the state it was looked up against
    typedef struct packed {
        logic [REQ_W-1:0]  req;
        logic [EDGE_W-1:0] edge_id;
        logic [NODE_W-1:0] end_node;
        logic [NODE_W-1:0] anchor;
        logic [NODE_W-1:0] run_end;
        logic              in_run;
        logic              prev_raw;
        logic              last;
    } look_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [VALUE_W-1:0] value;
        logic               last;
    } code_t;

    typedef struct packed {
        logic [1:0] count;
        code_t      first;
        code_t      second;
    } code_pair_t;

endpackage

### rtl/core/spt_edge_mem.sv
// edge endpoint table: start and end node of every edge
// synchronous memory, one write and one registered read; uses spt_pkg
module spt_edge_mem (
    input  logic                          aclk,
    input  logic                          wr_en,
    input  logic [spt_pkg::EDGE_W-1:0]    wr_addr,
    input  spt_pkg::endpoints_t           wr_data,
    input  logic                          rd_en,
    input  logic [spt_pkg::EDGE_W-1:0]    rd_addr,
    output spt_pkg::endpoints_t           rd_data
);

    spt_pkg::endpoints_t mem [spt_pkg::EDGE_COUNT];
    spt_pkg::endpoints_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/spt_path_mem.sv
// path table: last edge of the shortest path for every node pair
// one write port, two registered read ports, clearing sweep after reset; uses spt_pkg
module spt_path_mem (
    input  logic                          aclk,
    input  logic                          aresetn,
    output logic                          clear_done,
    input  logic                          wr_en,
    input  logic [spt_pkg::PATH_AW-1:0]   wr_addr,
    input  spt_pkg::path_entry_t          wr_data,
    input  logic                          rd_en,
    input  logic [spt_pkg::PATH_AW-1:0]   rd_addr_a,
    input  logic [spt_pkg::PATH_AW-1:0]   rd_addr_b,
    output spt_pkg::path_entry_t          rd_data_a,
    output spt_pkg::path_entry_t          rd_data_b
);

    localparam logic [spt_pkg::PATH_AW-1:0] LAST_ADDR = spt_pkg::PATH_AW'(spt_pkg::PATH_DEPTH - 1);

    spt_pkg::path_entry_t mem [spt_pkg::PATH_DEPTH];
    spt_pkg::path_entry_t rd_data_a_reg;
    spt_pkg::path_entry_t rd_data_b_reg;
    logic                          clearing_reg;
    logic [spt_pkg::PATH_AW-1:0]   clr_addr_reg;
    logic                          mem_we;
    logic [spt_pkg::PATH_AW-1:0]   mem_wa;
    spt_pkg::path_entry_t          mem_wd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clearing_reg) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == LAST_ADDR) begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // sweep writes no-path entries, normal writes only once it is done
    always_comb begin
        mem_we = clearing_reg | wr_en;
        mem_wa = clearing_reg ? clr_addr_reg : wr_addr;
        mem_wd = clearing_reg ? '0 : wr_data;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_a_reg <= mem[rd_addr_a];
            rd_data_b_reg <= mem[rd_addr_b];
        end
    end

    assign clear_done = ~clearing_reg;
    assign rd_data_a  = rd_data_a_reg;
    assign rd_data_b  = rd_data_b_reg;

endmodule

### rtl/core/spt_ctrl.sv
// trajectory state and code decision for one looked-up edge
// holds the run state registers, forwards the updated state; uses spt_pkg
module spt_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  item_valid,
    input  logic                  item_fire,
    input  spt_pkg::look_t        item,
    input  spt_pkg::path_entry_t  path_a,
    input  spt_pkg::path_entry_t  path_b,
    output spt_pkg::traj_state_t  state_eff,
    output spt_pkg::code_pair_t   codes
);

    localparam int PAD_W = spt_pkg::VALUE_W - spt_pkg::NODE_W;

    spt_pkg::traj_state_t state_reg;
    spt_pkg::traj_state_t state_next;
    logic                 is_traj;
    logic                 ok_a;
    logic                 ok_b;
    logic                 ok_sel;
    logic                 raw_sel;
    logic [spt_pkg::NODE_W-1:0] src;
    logic                 prim_en;
    spt_pkg::code_t       prim;
    spt_pkg::code_t       fin;

    assign is_traj = (item.req == spt_pkg::REQ_TRAJ);

    always_comb begin
        ok_a = path_a.valid && (path_a.id == item.edge_id);
        ok_b = path_b.valid && (path_b.id == item.edge_id);

        state_next          = state_reg;
        state_next.anchor   = item.anchor;
        state_next.run_end  = item.run_end;
        state_next.in_run   = item.in_run;
        state_next.prev_raw = item.prev_raw;
        state_next.started  = 1'b1;

        // a broken run restarts from its end node
        src     = item.in_run ? item.run_end : item.anchor;
        ok_sel  = item.in_run ? ok_b : ok_a;
        raw_sel = item.in_run ? 1'b0 : item.prev_raw;

        prim_en    = 1'b0;
        prim.kind  = spt_pkg::KIND_RAW;
        prim.value = item.edge_id;
        prim.last  = 1'b0;

        if (item.in_run && ok_a) begin
            state_next.run_end = item.end_node;
        end else begin
            state_next.anchor = src;
            if (ok_sel) begin
                prim_en             = ~raw_sel;
                prim.kind           = spt_pkg::KIND_ANCHOR;
                prim.value          = {{PAD_W{1'b0}}, src};
                state_next.in_run   = 1'b1;
                state_next.prev_raw = 1'b0;
                state_next.run_end  = item.end_node;
            end else begin
                prim_en             = 1'b1;
                state_next.in_run   = 1'b0;
                state_next.prev_raw = 1'b1;
                state_next.anchor   = item.end_node;
            end
        end

        fin.kind  = spt_pkg::KIND_FINAL;
        fin.value = {{PAD_W{1'b0}}, item.end_node};
        fin.last  = 1'b1;

        if (item.last) begin
            state_next.started  = 1'b0;
            state_next.in_run   = 1'b0;
            state_next.prev_raw = 1'b0;
        end

        codes.count       = is_traj ? ({1'b0, prim_en} + {1'b0, item.last}) : 2'd0;
        codes.first       = prim_en ? prim : fin;
        codes.first.last  = ~(prim_en & item.last);
        codes.second      = fin;
    end

    assign state_eff = (item_valid && is_traj) ? state_next : state_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (item_fire && is_traj) begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTHESIS
    a_final_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (item_fire && is_traj && item.last) |=> (!state_reg.started && !state_reg.in_run))
        else $error("final edge left the trajectory open");

    a_edge_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (item_fire && is_traj && !item.last) |=> state_reg.started)
        else $error("trajectory edge did not mark the trajectory started");
`endif

endmodule

### rtl/core/spt_out_buf.sv
// result queue: takes up to two codes per item, hands out one per transaction
// four-entry register queue; uses spt_pkg
module spt_out_buf (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  spt_pkg::code_pair_t   codes,
    output logic                  room,
    output logic                  m_valid,
    input  logic                  m_ready,
    output spt_pkg::code_t        head
);

    localparam logic [spt_pkg::OBUF_CW-1:0] ROOM_MAX = spt_pkg::OBUF_CW'(spt_pkg::OBUF_DEPTH - 2);

    spt_pkg::code_t                 entry_reg [spt_pkg::OBUF_DEPTH];
    logic [spt_pkg::OBUF_AW-1:0]    wr_ptr_reg;
    logic [spt_pkg::OBUF_AW-1:0]    rd_ptr_reg;
    logic [spt_pkg::OBUF_CW-1:0]    count_reg;
    logic [1:0]                     push_n;
    logic                           pop;

    assign push_n  = push ? codes.count : 2'd0;
    assign pop     = m_valid && m_ready;
    assign m_valid = (count_reg != '0);
    assign room    = (count_reg <= ROOM_MAX);
    assign head    = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            entry_reg[wr_ptr_reg] <= codes.first;
        end
        if (push_n == 2'd2) begin
            entry_reg[wr_ptr_reg + 1'b1] <= codes.second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + spt_pkg::OBUF_AW'(push_n);
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + spt_pkg::OBUF_CW'(push_n)
                         - spt_pkg::OBUF_CW'(pop);
        end
    end

endmodule

### rtl/core/shortest_path_trajectory_compressor.sv
// Shortest-path trajectory compressor. Takes one item per cycle (loads and trajectory edges
// alike) as long as the result queue has room; an item with an anchor or raw code plus a final
// node gives two results. An edge passes the endpoint read, the path-table read on two ports
// (current anchor and run end) and the decision, then enters the result queue, with the decided
// state forwarded straight into the next edge's path-table address. After reset all 1,048,576
// path-table entries are swept to no-path, during which s_ready stays low.
// Depends on spt_pkg, spt_edge_mem, spt_path_mem, spt_ctrl and spt_out_buf.
module shortest_path_trajectory_compressor (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [spt_pkg::REQ_W-1:0]     s_req_type,
    input  logic [spt_pkg::EDGE_W-1:0]    s_edge_id,
    input  logic [spt_pkg::NODE_W-1:0]    s_from_node,
    input  logic [spt_pkg::NODE_W-1:0]    s_to_node,
    input  logic                          s_entry_valid,
    input  logic                          s_last_edge,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [spt_pkg::KIND_W-1:0]    m_code_kind,
    output logic [spt_pkg::VALUE_W-1:0]   m_code_value,
    output logic                          m_last_of_item
);

    logic                          accept;
    logic                          clear_done;

    // endpoint stage
    logic                          s1_valid_reg;
    logic [spt_pkg::REQ_W-1:0]     s1_req_reg;
    logic [spt_pkg::EDGE_W-1:0]    s1_edge_reg;
    logic [spt_pkg::NODE_W-1:0]    s1_from_reg;
    logic [spt_pkg::NODE_W-1:0]    s1_to_reg;
    logic                          s1_entry_valid_reg;
    logic                          s1_last_reg;
    logic                          s1_adv;
    spt_pkg::endpoints_t           ends;

    // decide stage
    logic                          s2_valid_reg;
    spt_pkg::look_t                s2_item_reg;
    spt_pkg::look_t                s2_item_next;
    logic                          s2_fire;

    spt_pkg::traj_state_t          state_eff;
    logic                          path_rd_en;
    logic [spt_pkg::PATH_AW-1:0]   path_addr_a;
    logic [spt_pkg::PATH_AW-1:0]   path_addr_b;
    logic                          path_wr_en;
    spt_pkg::path_entry_t          path_wr_data;
    spt_pkg::path_entry_t          path_a;
    spt_pkg::path_entry_t          path_b;
    spt_pkg::endpoints_t           edge_wr_data;
    spt_pkg::code_pair_t           codes;
    spt_pkg::code_t                head;
    logic                          room;

    assign s2_fire = s2_valid_reg && room;
    assign s1_adv  = s1_valid_reg && (!s2_valid_reg || s2_fire);
    assign s_ready = clear_done && (!s1_valid_reg || s1_adv);
    assign accept  = s_valid && s_ready;

    assign edge_wr_data.start_node = s_from_node;
    assign edge_wr_data.end_node   = s_to_node;

    spt_edge_mem u_edge_mem (
        .aclk    (aclk),
        .wr_en   (accept && (s_req_type == spt_pkg::REQ_EDGE)),
        .wr_addr (s_edge_id),
        .wr_data (edge_wr_data),
        .rd_en   (accept && (s_req_type == spt_pkg::REQ_TRAJ)),
        .rd_addr (s_edge_id),
        .rd_data (ends)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_req_reg         <= s_req_type;
            s1_edge_reg        <= s_edge_id;
            s1_from_reg        <= s_from_node;
            s1_to_reg          <= s_to_node;
            s1_entry_valid_reg <= s_entry_valid;
            s1_last_reg        <= s_last_edge;
        end
    end

    // first edge of a trajectory anchors at its own start node
    always_comb begin
        s2_item_next.req      = s1_req_reg;
        s2_item_next.edge_id  = s1_edge_reg;
        s2_item_next.end_node = ends.end_node;
        s2_item_next.anchor   = state_eff.started ? state_eff.anchor : ends.start_node;
        s2_item_next.run_end  = state_eff.run_end;
        s2_item_next.in_run   = state_eff.started && state_eff.in_run;
        s2_item_next.prev_raw = state_eff.started && state_eff.prev_raw;
        s2_item_next.last     = s1_last_reg;
    end

    assign path_rd_en   = s1_adv && (s1_req_reg == spt_pkg::REQ_TRAJ);
    assign path_addr_a  = {s2_item_next.anchor, ends.end_node};
    assign path_addr_b  = {state_eff.run_end, ends.end_node};
    assign path_wr_en   = s1_adv && (s1_req_reg == spt_pkg::REQ_PATH);
    assign path_wr_data.valid = s1_entry_valid_reg;
    assign path_wr_data.id    = s1_entry_valid_reg ? s1_edge_reg : '0;

    spt_path_mem u_path_mem (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .clear_done (clear_done),
        .wr_en      (path_wr_en),
        .wr_addr    ({s1_from_reg, s1_to_reg}),
        .wr_data    (path_wr_data),
        .rd_en      (path_rd_en),
        .rd_addr_a  (path_addr_a),
        .rd_addr_b  (path_addr_b),
        .rd_data_a  (path_a),
        .rd_data_b  (path_b)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            s2_valid_reg <= 1'b1;
        end else if (s2_fire) begin
            s2_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            s2_item_reg <= s2_item_next;
        end
    end

    spt_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (s2_valid_reg),
        .item_fire  (s2_fire),
        .item       (s2_item_reg),
        .path_a     (path_a),
        .path_b     (path_b),
        .state_eff  (state_eff),
        .codes      (codes)
    );

    spt_out_buf u_out_buf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (s2_fire),
        .codes   (codes),
        .room    (room),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .head    (head)
    );

    assign m_code_kind    = head.kind;
    assign m_code_value   = head.value;
    assign m_last_of_item = head.last;

`ifndef SYNTHESIS
    a_no_accept_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        !clear_done |-> !s_ready)
        else $error("transaction accepted during path table sweep");

    a_loads_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (s2_valid_reg && (s2_item_reg.req != spt_pkg::REQ_TRAJ)) |-> (codes.count == 2'd0))
        else $error("load item produced a code");
`endif

endmodule
